/* hw/rtl/iterative_linear_solver_defines.svh */
// assertion macros used by the solver top level
`ifndef ITERATIVE_LINEAR_SOLVER_DEFINES_SVH
`define ITERATIVE_LINEAR_SOLVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ILS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("solver assertion failed");

// next-cycle implication, checked out of reset
`define ILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("solver assertion failed");

`endif

/* hw/rtl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

  localparam int DATA_W     = 64;
  localparam int FRAC_W     = 40;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int CNT_W      = 4;
  localparam int SWP_W      = 16;
  localparam int TOL_W      = 41;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 41;

  localparam logic [DATA_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SMIN = 64'h8000_0000_0000_0000;

  // result status codes
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIT  = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [DATA_W-1:0] coef_value;
    logic                     load_last;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         unknown_index;
    logic signed [DATA_W-1:0] solution_value;
    logic [SWP_W-1:0]         sweeps_done;
    logic [1:0]               status;
    logic                     result_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             load_wr;
    logic             x_clear;
    logic             diag_ld;
    logic             div_start;
    logic             div_step;
    logic             norm_wr;
    logic             prev_copy;
    logic             chg_clr;
    logic             acc_ld;
    logic             mul_ld;
    logic             mul_step;
    logic [1:0]       mul_sel;
    logic             mul_fin;
    logic             acc_sub;
    logic             x_wr;
    logic             chg_upd;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic diag_zero;
    logic conv;
  } sts_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [DATA_W-1:0] signed_sat(input logic neg,
                                                   input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] res;
    if (neg) begin
      res = m[DATA_W-1] ? SMIN : (64'd0 - m);
    end else begin
      res = m[DATA_W-1] ? SMAX : m;
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] res;
    s = a - b;
    if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
      res = a[DATA_W-1] ? SMIN : SMAX;
    end else begin
      res = s;
    end
    return res;
  endfunction

  // absolute value clamped to the largest positive value
  function automatic logic [DATA_W-1:0] change_mag(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = magnitude(v);
    return m[DATA_W-1] ? SMAX : m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ils_ram.sv */
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 72
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/ils_dpath.sv */
`default_nettype none

module ils_dpath #(
  parameter int MAX_UNKNOWNS = 8
) (
  input  wire logic                            clk,
  input  wire ils_pkg::in_item_t               in_data,
  input  wire logic                            method,
  input  wire logic [ils_pkg::TOL_W-1:0]       tolerance,
  input  wire ils_pkg::cmd_t                   cmd,
  output ils_pkg::sts_t                        sts,
  output logic      [ils_pkg::DATA_W-1:0]      x_sel
);

  localparam int COLS  = MAX_UNKNOWNS + 1;
  localparam int DEPTH = MAX_UNKNOWNS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_UNKNOWNS);
  localparam int DW    = ils_pkg::DATA_W;

  logic [AW-1:0] coef_waddr;
  logic          coef_we;
  logic [AW-1:0] rc_addr;
  logic [DW-1:0] coef_rd;
  logic [DW-1:0] norm_rd;
  logic [DW-1:0] div_res;
  logic [IW-1:0] row_idx;
  logic [IW-1:0] col_idx;
  logic [DW-1:0] xj;

  logic [DW-1:0] x_r    [MAX_UNKNOWNS];
  logic [DW-1:0] prev_r [MAX_UNKNOWNS];

  logic [DW-1:0] d_mag_r;
  logic          d_neg_r;
  logic [DW:0]   r_r;
  logic [DW-1:0] lo_r;
  logic [DW-1:0] q_r;
  logic          qneg_r;
  logic          dsat_r;
  logic [DW-1:0] nm;
  logic [DW:0]   rs;
  logic          ge;

  logic [DW-1:0]   ma_r;
  logic [DW-1:0]   mb_r;
  logic            mneg_r;
  logic [2*DW-1:0] prod_r;
  logic [DW-1:0]   p_r;
  logic [31:0]     opa;
  logic [31:0]     opb;
  logic [6:0]      sh;
  logic [DW-1:0]   pp;
  logic [2*DW-1:0] pp_sh;

  logic [DW-1:0] acc_r;
  logic [DW-1:0] diff_r;
  logic [DW-1:0] chg_r;

  // store addressing
  assign coef_waddr = AW'(32'(in_data.row_index) * 32'(COLS) + 32'(in_data.col_index));
  assign coef_we    = cmd.load_wr
                      && (32'(in_data.row_index) < 32'(MAX_UNKNOWNS))
                      && (32'(in_data.col_index) < 32'(COLS));
  assign rc_addr    = AW'(32'(cmd.row) * 32'(COLS) + 32'(cmd.col));
  assign row_idx    = cmd.row[IW-1:0];
  assign col_idx    = cmd.col[IW-1:0];

  ils_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_data.coef_value),
    .raddr (rc_addr),
    .rdata (coef_rd)
  );

  ils_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_norm_ram (
    .clk   (clk),
    .we    (cmd.norm_wr),
    .waddr (rc_addr),
    .wdata (div_res),
    .raddr (rc_addr),
    .rdata (norm_rd)
  );

  // restoring divider, one quotient bit per step
  assign nm      = ils_pkg::magnitude(coef_rd);
  assign rs      = {r_r[DW-1:0], lo_r[DW-1]};
  assign ge      = rs >= {1'b0, d_mag_r};
  assign div_res = dsat_r ? (qneg_r ? ils_pkg::SMIN : ils_pkg::SMAX)
                          : ils_pkg::signed_sat(qneg_r, q_r);

  // partial product select
  always_comb begin
    case (cmd.mul_sel)
      2'd0:    begin opa = ma_r[31:0];  opb = mb_r[31:0];  sh = 7'd0;  end
      2'd1:    begin opa = ma_r[31:0];  opb = mb_r[63:32]; sh = 7'd32; end
      2'd2:    begin opa = ma_r[63:32]; opb = mb_r[31:0];  sh = 7'd32; end
      default: begin opa = ma_r[63:32]; opb = mb_r[63:32]; sh = 7'd64; end
    endcase
  end

  assign pp    = 64'(opa) * 64'(opb);
  assign pp_sh = {64'd0, pp} << sh;
  assign xj    = method ? x_r[col_idx] : prev_r[col_idx];

  // solution vector and previous sweep copy
  always_ff @(posedge clk) begin
    if (cmd.x_clear) begin
      for (int k = 0; k < MAX_UNKNOWNS; k++) begin
        x_r[k] <= '0;
      end
    end else if (cmd.x_wr) begin
      x_r[row_idx] <= acc_r;
    end
    if (cmd.prev_copy) begin
      prev_r <= x_r;
    end
  end

  // diagonal capture and divider
  always_ff @(posedge clk) begin
    if (cmd.diag_ld) begin
      d_mag_r <= ils_pkg::magnitude(coef_rd);
      d_neg_r <= coef_rd[DW-1];
    end
    if (cmd.div_start) begin
      dsat_r <= {24'd0, nm[63:24]} >= d_mag_r;
      r_r    <= {25'd0, nm[63:24]};
      lo_r   <= {nm[23:0], 40'd0};
      q_r    <= '0;
      qneg_r <= coef_rd[DW-1] ^ d_neg_r;
    end else if (cmd.div_step) begin
      r_r  <= ge ? (rs - {1'b0, d_mag_r}) : rs;
      q_r  <= {q_r[DW-2:0], ge};
      lo_r <= {lo_r[DW-2:0], 1'b0};
    end
  end

  // multiplier over four partial products, then saturate
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      ma_r   <= ils_pkg::magnitude(norm_rd);
      mb_r   <= ils_pkg::magnitude(xj);
      mneg_r <= norm_rd[DW-1] ^ xj[DW-1];
      prod_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r <= prod_r + pp_sh;
    end
    if (cmd.mul_fin) begin
      p_r <= (|prod_r[127:104]) ? (mneg_r ? ils_pkg::SMIN : ils_pkg::SMAX)
                                : ils_pkg::signed_sat(mneg_r, prod_r[103:40]);
    end
  end

  // row accumulator and largest change
  always_ff @(posedge clk) begin
    if (cmd.acc_ld) begin
      acc_r <= norm_rd;
    end else if (cmd.acc_sub) begin
      acc_r <= ils_pkg::sub_sat(acc_r, p_r);
    end
    if (cmd.x_wr) begin
      diff_r <= ils_pkg::change_mag(ils_pkg::sub_sat(acc_r, prev_r[row_idx]));
    end
    if (cmd.chg_clr) begin
      chg_r <= '0;
    end else if (cmd.chg_upd && (diff_r > chg_r)) begin
      chg_r <= diff_r;
    end
  end

  assign sts.diag_zero = (d_mag_r == '0);
  assign sts.conv      = chg_r <= {23'd0, tolerance};
  assign x_sel         = x_r[row_idx];

endmodule

`default_nettype wire

/* hw/rtl/ils_ctrl.sv */
`default_nettype none

module ils_ctrl #(
  parameter int MAX_UNKNOWNS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_last,
  output logic                              in_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  input  wire logic [ils_pkg::CNT_W-1:0]    system_size,
  input  wire logic [ils_pkg::SWP_W-1:0]    max_iterations,
  input  wire ils_pkg::sts_t                sts,
  output ils_pkg::cmd_t                     cmd,
  output logic      [ils_pkg::ROW_W-1:0]    out_index,
  output logic      [ils_pkg::SWP_W-1:0]    sweeps,
  output logic      [1:0]                   status,
  output logic                              out_last
);

  localparam int CW = ils_pkg::CNT_W;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_DG_RD    = 20'h00002,
    S_DG_LD    = 20'h00004,
    S_DG_CHK   = 20'h00008,
    S_DV_RD    = 20'h00010,
    S_DV_INIT  = 20'h00020,
    S_DV_RUN   = 20'h00040,
    S_DV_WR    = 20'h00080,
    S_SW_START = 20'h00100,
    S_AC_RD    = 20'h00200,
    S_AC_LD    = 20'h00400,
    S_MC_CHK   = 20'h00800,
    S_MC_LD    = 20'h01000,
    S_MC_RUN   = 20'h02000,
    S_MC_FIN   = 20'h04000,
    S_MC_SUB   = 20'h08000,
    S_XW       = 20'h10000,
    S_CHG      = 20'h20000,
    S_SW_END   = 20'h40000,
    S_OUT      = 20'h80000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             j_r, j_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      zflag_r, zflag_nxt;
  logic [ils_pkg::SWP_W-1:0] sweeps_r, sweeps_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [CW-1:0]             n_w;
  logic [ils_pkg::SWP_W-1:0] lim_w;
  logic                      i_last;

  // active size and sweep limit
  always_comb begin
    if (system_size == '0) begin
      n_w = CW'(1);
    end else if (32'(system_size) > 32'(MAX_UNKNOWNS)) begin
      n_w = CW'(MAX_UNKNOWNS);
    end else begin
      n_w = system_size;
    end
  end

  assign lim_w  = (max_iterations == '0) ? 16'd1 : max_iterations;
  assign i_last = (i_r == (n_w - CW'(1)));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    zflag_nxt  = zflag_r;
    sweeps_nxt = sweeps_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.row    = i_r;
    cmd.col    = j_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_wr = in_valid;
        if (in_valid && in_last) begin
          cmd.x_clear = 1'b1;
          i_nxt       = '0;
          zflag_nxt   = 1'b0;
          sweeps_nxt  = '0;
          state_nxt   = S_DG_RD;
        end
      end
      S_DG_RD: begin
        cmd.col   = i_r;
        state_nxt = S_DG_LD;
      end
      S_DG_LD: begin
        cmd.diag_ld = 1'b1;
        state_nxt   = S_DG_CHK;
      end
      S_DG_CHK: begin
        if (sts.diag_zero) begin
          zflag_nxt = 1'b1;
          if (i_last) begin
            status_nxt = ils_pkg::ST_ZERO_DIAG;
            i_nxt      = '0;
            state_nxt  = S_OUT;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_DG_RD;
          end
        end else begin
          j_nxt     = '0;
          state_nxt = S_DV_RD;
        end
      end
      S_DV_RD: begin
        state_nxt = S_DV_INIT;
      end
      S_DV_INIT: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DV_RUN;
      end
      S_DV_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_DV_WR;
        end
      end
      S_DV_WR: begin
        cmd.norm_wr = 1'b1;
        if (j_r == n_w) begin
          if (i_last) begin
            i_nxt = '0;
            if (zflag_r) begin
              status_nxt = ils_pkg::ST_ZERO_DIAG;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_SW_START;
            end
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_DG_RD;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_DV_RD;
        end
      end
      S_SW_START: begin
        cmd.prev_copy = 1'b1;
        cmd.chg_clr   = 1'b1;
        sweeps_nxt    = sweeps_r + 16'd1;
        i_nxt         = '0;
        state_nxt     = S_AC_RD;
      end
      S_AC_RD: begin
        cmd.col   = n_w;
        state_nxt = S_AC_LD;
      end
      S_AC_LD: begin
        cmd.acc_ld = 1'b1;
        j_nxt      = '0;
        state_nxt  = S_MC_CHK;
      end
      S_MC_CHK: begin
        if (j_r == n_w) begin
          state_nxt = S_XW;
        end else if (j_r == i_r) begin
          j_nxt = j_r + CW'(1);
        end else begin
          state_nxt = S_MC_LD;
        end
      end
      S_MC_LD: begin
        cmd.mul_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_MC_RUN;
      end
      S_MC_RUN: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel  = cnt_r[1:0];
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = S_MC_FIN;
        end
      end
      S_MC_FIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_MC_SUB;
      end
      S_MC_SUB: begin
        cmd.acc_sub = 1'b1;
        j_nxt       = j_r + CW'(1);
        state_nxt   = S_MC_CHK;
      end
      S_XW: begin
        cmd.x_wr  = 1'b1;
        state_nxt = S_CHG;
      end
      S_CHG: begin
        cmd.chg_upd = 1'b1;
        if (i_last) begin
          state_nxt = S_SW_END;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_AC_RD;
        end
      end
      S_SW_END: begin
        i_nxt = '0;
        if (sts.conv) begin
          status_nxt = ils_pkg::ST_CONVERGED;
          state_nxt  = S_OUT;
        end else if (sweeps_r >= lim_w) begin
          status_nxt = ils_pkg::ST_LIMIT;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_SW_START;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (i_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      cnt_r    <= '0;
      zflag_r  <= 1'b0;
      sweeps_r <= '0;
      status_r <= ils_pkg::ST_CONVERGED;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      cnt_r    <= cnt_nxt;
      zflag_r  <= zflag_nxt;
      sweeps_r <= sweeps_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_index = i_r[ils_pkg::ROW_W-1:0];
  assign sweeps    = sweeps_r;
  assign status    = status_r;
  assign out_last  = i_last;

endmodule

`default_nettype wire

/* hw/rtl/iterative_linear_solver.sv */
// jacobi / gauss-seidel solver, q23.40, one coefficient transfer per cycle while loading
// solve: normalization by the 64-step divider,
// then sweeps that use the 4-step multiplier
// results: n transfers, one per cycle while out_ready is high; next input accepted after the last result
// reset: synchronous active-low rst_n clears control state and config registers;
// coefficient store is not cleared
`default_nettype none

`include "iterative_linear_solver_defines.svh"

module iterative_linear_solver #(
  parameter int MAX_UNKNOWNS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ils_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ils_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [ils_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ils_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                         method_r;
  logic [ils_pkg::CNT_W-1:0]    size_r;
  logic [ils_pkg::TOL_W-1:0]    tol_r;
  logic [ils_pkg::SWP_W-1:0]    maxit_r;
  ils_pkg::cmd_t                cmd;
  ils_pkg::sts_t                sts;
  logic [ils_pkg::DATA_W-1:0]   x_sel;
  logic [ils_pkg::ROW_W-1:0]    out_index;
  logic [ils_pkg::SWP_W-1:0]    sweeps;
  logic [1:0]                   status;
  logic                         out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b0;
      size_r   <= 4'd4;
      tol_r    <= 41'd110;
      maxit_r  <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ils_pkg::CFG_METHOD: method_r <= cfg_wdata[0];
        ils_pkg::CFG_SIZE:   size_r   <= cfg_wdata[ils_pkg::CNT_W-1:0];
        ils_pkg::CFG_TOL:    tol_r    <= cfg_wdata[ils_pkg::TOL_W-1:0];
        ils_pkg::CFG_MAXIT:  maxit_r  <= cfg_wdata[ils_pkg::SWP_W-1:0];
        default:             method_r <= method_r;
      endcase
    end
  end

  ils_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last        (in_data.load_last),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .system_size    (size_r),
    .max_iterations (maxit_r),
    .sts            (sts),
    .cmd            (cmd),
    .out_index      (out_index),
    .sweeps         (sweeps),
    .status         (status),
    .out_last       (out_last)
  );

  ils_dpath #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_dpath (
    .clk       (clk),
    .in_data   (in_data),
    .method    (method_r),
    .tolerance (tol_r),
    .cmd       (cmd),
    .sts       (sts),
    .x_sel     (x_sel)
  );

  // result payload
  assign out_data.unknown_index  = out_index;
  assign out_data.solution_value = x_sel;
  assign out_data.sweeps_done    = sweeps;
  assign out_data.status         = status;
  assign out_data.result_last    = out_last;

  // checks
  `ILS_ASSERT_IMP(a_no_load_during_results, out_valid, !in_ready)
  `ILS_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && out_data.result_last, in_ready)
  `ILS_ASSERT_IMP(a_zero_diag_no_sweeps, out_valid && (out_data.status == ils_pkg::ST_ZERO_DIAG), out_data.sweeps_done == '0)
  `ILS_ASSERT_IMP(a_sweeps_in_limit, out_valid && (out_data.status == ils_pkg::ST_LIMIT), out_data.sweeps_done != '0)

endmodule

`default_nettype wire

/* verif/ils_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ils_checker
  import ils_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire out_item_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  localparam int NCOLS = 9;

  // shadow of the configuration registers
  logic              sh_method;
  logic [3:0]        sh_size;
  logic [TOL_W-1:0]  sh_tol;
  logic [SWP_W-1:0]  sh_maxit;

  logic signed [DATA_W-1:0] coef_mem [0:8*NCOLS-1];
  out_item_t                solution_q [$];

  function automatic logic signed [DATA_W-1:0] to_sat(input logic neg,
                                                     input logic [DATA_W-1:0] m);
    if (neg) return m[DATA_W-1] ? SMIN : -m;
    return m[DATA_W-1] ? SMAX : m;
  endfunction

  function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  function automatic logic signed [DATA_W-1:0] q_sub(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) return d[DATA_W] ? SMIN : SMAX;
    return d[DATA_W-1:0];
  endfunction

  // exact product, magnitude truncated back to q23.40
  function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic [127:0] p;
    logic         neg;
    neg = a[DATA_W-1] ^ b[DATA_W-1];
    p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    if (p[127:104] != 0) return neg ? SMIN : SMAX;
    return to_sat(neg, p[103:40]);
  endfunction

  // divisor is never zero here
  function automatic logic signed [DATA_W-1:0] q_div(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb;
    logic [103:0]      q;
    logic              neg;
    neg = a[DATA_W-1] ^ b[DATA_W-1];
    ma = mag_of(a);
    mb = mag_of(b);
    if ((ma >> 24) >= mb) return neg ? SMIN : SMAX;
    q = {ma, 40'd0} / {40'd0, mb};
    return to_sat(neg, q[63:0]);
  endfunction

  // normalize, sweep until settled or out of sweeps, queue one result per unknown
  task automatic solve_system();
    logic signed [DATA_W-1:0] norm [0:8*NCOLS-1];
    logic signed [DATA_W-1:0] x [0:7];
    logic signed [DATA_W-1:0] prev [0:7];
    logic signed [DATA_W-1:0] acc, diag, xj;
    logic [DATA_W-1:0]        chg, worst;
    logic [1:0]               st;
    logic                     zero_diag;
    int                       n, sweeps, lim;
    out_item_t                r;
    n = (sh_size < 1) ? 1 : (sh_size > 8) ? 8 : int'(sh_size);
    lim = (sh_maxit == 0) ? 1 : int'(sh_maxit);
    sweeps = 0;
    zero_diag = 1'b0;
    for (int i = 0; i < 8; i++) x[i] = '0;
    for (int i = 0; i < n; i++) begin
      diag = coef_mem[i*NCOLS+i];
      if (diag == 0) begin
        zero_diag = 1'b1;
      end else begin
        for (int j = 0; j <= n; j++) norm[i*NCOLS+j] = q_div(coef_mem[i*NCOLS+j], diag);
      end
    end
    if (zero_diag) begin
      st = ST_ZERO_DIAG;
    end else begin
      while (1) begin
        sweeps++;
        for (int i = 0; i < 8; i++) prev[i] = x[i];
        for (int i = 0; i < n; i++) begin
          acc = norm[i*NCOLS+n];
          for (int j = 0; j < n; j++) begin
            if (j != i) begin
              xj = sh_method ? x[j] : prev[j];
              acc = q_sub(acc, q_mul(norm[i*NCOLS+j], xj));
            end
          end
          x[i] = acc;
        end
        worst = '0;
        for (int i = 0; i < n; i++) begin
          chg = mag_of(q_sub(x[i], prev[i]));
          if (chg[DATA_W-1]) chg = SMAX;
          if (chg > worst) worst = chg;
        end
        if (worst <= {23'd0, sh_tol}) begin
          st = ST_CONVERGED;
          break;
        end
        if (sweeps >= lim) begin
          st = ST_LIMIT;
          break;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.unknown_index  = i[ROW_W-1:0];
      r.solution_value = x[i];
      r.sweeps_done    = sweeps[SWP_W-1:0];
      r.status         = st;
      r.result_last    = (i == n - 1);
      solution_q.push_back(r);
    end
  endtask

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      sh_method = 1'b0;
      sh_size   = 4'd4;
      sh_tol    = TOL_W'(110);
      sh_maxit  = SWP_W'(1000);
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_METHOD: sh_method = cfg_wdata[0];
          CFG_SIZE:   sh_size   = cfg_wdata[3:0];
          CFG_TOL:    sh_tol    = cfg_wdata[TOL_W-1:0];
          CFG_MAXIT:  sh_maxit  = cfg_wdata[SWP_W-1:0];
          default: ;
        endcase
      end
      // coefficient transfer
      if (in_valid && in_ready) begin
        if (in_data.col_index < NCOLS)
          coef_mem[in_data.row_index*NCOLS + in_data.col_index] = in_data.coef_value;
        if (in_data.load_last) solve_system();
      end
      // result transfer
      if (out_valid && out_ready) begin
        if (solution_q.size() == 0) begin
          report("unexpected result", out_data.solution_value, '0);
        end else begin
          w = solution_q.pop_front();
          if (out_data.unknown_index != w.unknown_index)
            report("unknown_index", out_data.unknown_index, w.unknown_index);
          if (out_data.solution_value != w.solution_value)
            report("solution_value", out_data.solution_value, w.solution_value);
          if (out_data.sweeps_done != w.sweeps_done)
            report("sweeps_done", out_data.sweeps_done, w.sweeps_done);
          if (out_data.status != w.status)
            report("status", out_data.status, w.status);
          if (out_data.result_last != w.result_last)
            report("result_last", out_data.result_last, w.result_last);
        end
      end
      pending = solution_q.size();
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import ils_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic signed [DATA_W-1:0] ONE = 64'sd1 <<< FRAC_W;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  iterative_linear_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ils_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  logic signed [DATA_W-1:0] mat [0:7][0:8];
  logic [3:0] size_reg;
  int         coef_sent;
  int         burst_left;
  int         hold_asked;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int active_n();
    return (size_reg < 1) ? 1 : (size_reg > 8) ? 8 : int'(size_reg);
  endfunction

  // one coefficient transfer, then maybe a gap before the next burst
  task automatic put(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                     input logic signed [DATA_W-1:0] v, input logic last);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = '{row_index: row, col_index: col, coef_value: v, load_last: last};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    if (idx == CFG_SIZE) size_reg = v[3:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(input logic m, input logic [3:0] sz,
                         input logic [TOL_W-1:0] tol, input logic [SWP_W-1:0] mi);
    set_reg(CFG_METHOD, CFG_DATA_W'(m));
    set_reg(CFG_SIZE, CFG_DATA_W'(sz));
    set_reg(CFG_TOL, CFG_DATA_W'(tol));
    set_reg(CFG_MAXIT, CFG_DATA_W'(mi));
  endtask

  // stop sending and wait for every queued solution, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  // load the active system with dropped noise columns mixed in; the last
  // transfer starts the solve, or a dropped column does when tail is set
  task automatic load_system(input bit tail);
    int n;
    n = active_n();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= n; j++) begin
        if ($urandom_range(0, 7) == 0)
          put($urandom_range(0, 7), $urandom_range(9, 15), rand64(), 1'b0);
        put(i, j, mat[i][j], !tail && i == n - 1 && j == n);
        coef_sent++;
      end
    end
    if (tail) put(3'd7, 4'd15, rand64(), 1'b1);
  endtask

  task automatic fill_dominant(input int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= n; j++) begin
        if (j == i) begin
          mat[i][j] = (64'(n + 1 + $urandom_range(0, 3)) << FRAC_W) + $urandom_range(0, 1 << 20);
          if ($urandom_range(0, 1)) mat[i][j] = -mat[i][j];
        end else if (j == n) begin
          mat[i][j] = 64'($signed($urandom)) <<< 11;
        end else begin
          mat[i][j] = 64'($signed($urandom)) <<< 7;
        end
      end
    end
  endtask

  task automatic fill_wild(input int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= n; j++) begin
        case ($urandom_range(0, 5))
          0: mat[i][j] = SMAX;
          1: mat[i][j] = SMIN;
          default: mat[i][j] = rand64();
        endcase
      end
    end
  endtask

  task automatic fill_identity(input int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= n; j++)
        mat[i][j] = (j == n) ? rand64() : (i == j) ? ONE : 64'sd0;
  endtask

  // receiver: stall patterns by segment, plus the long hold-off on request,
  // started once results are waiting
  initial begin
    int seg_left, mode, hold_left, hold_seen;
    out_ready = 1'b0;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked && out_valid) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left <= 0) begin
        seg_left = $urandom_range(5, 60);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          2: out_ready = (seg_left % 4) != 0;
          default: out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase, n, kind;
    logic [TOL_W-1:0] tol;
    logic [SWP_W-1:0] mi;
    logic [3:0]       sz;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    size_reg   = 4'd4;
    coef_sent  = 0;
    burst_left = 4;
    hold_asked = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero size acts as one unknown, zero sweep limit still runs a sweep,
    // the right-hand side at the most negative value
    set_all(1'b0, 4'd0, '0, '0);
    mat[0][0] = ONE;
    mat[0][1] = SMIN;
    load_system(0);
    drain();

    // zero diagonal in the second row
    set_all(1'b0, 4'd2, TOL_W'(110), SWP_W'(5));
    fill_dominant(2);
    mat[1][1] = '0;
    load_system(0);
    drain();

    // solve started by a coefficient in a dropped column
    set_all(1'b1, 4'd1, TOL_W'(110), SWP_W'(10));
    mat[0][0] = 64'sd2 <<< FRAC_W;
    mat[0][1] = SMAX;
    load_system(1);
    drain();

    // gauss-seidel with a tolerance of 1.0 and the longest sweep limit
    set_all(1'b1, 4'd2, TOL_W'(1) << 40, 16'hFFFF);
    fill_identity(2);
    mat[0][2] = SMAX;
    mat[1][2] = SMIN;
    load_system(0);
    drain();

    coef_sent = 0;
    phase     = 0;
    while (coef_sent < 220) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 7))
        0: sz = 4'd0;
        1: sz = ($urandom_range(0, 1)) ? 4'd8 : 4'd15;
        2: sz = $urandom_range(5, 7);
        default: sz = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0: tol = '0;
        1: tol = TOL_W'(1) << 40;
        2: tol = {$urandom, $urandom};
        3: tol = $urandom_range(0, 1 << 20);
        default: tol = TOL_W'(110);
      endcase
      if (kind >= 6) begin
        mi = $urandom_range(0, 6);
      end else if ($urandom_range(0, 4) == 0 && sz >= 1 && sz <= 3) begin
        mi = 16'hFFFF;
        if (tol < 110) tol = TOL_W'(110);
      end else begin
        mi = $urandom_range(1, 60);
      end
      set_all($urandom_range(0, 1), sz, tol, mi);
      n = active_n();
      case (kind)
        6, 7: fill_wild(n);
        8: fill_identity(n);
        9: begin
          fill_dominant(n);
          mat[$urandom_range(0, n - 1)][0] = '0;
          for (int i = 0; i < n; i++) if ($urandom_range(0, 2) == 0) mat[i][i] = '0;
        end
        default: fill_dominant(n);
      endcase
      if (phase == 3) begin
        // results back up behind a long receiver hold-off while the next load waits
        hold_asked++;
        load_system(0);
        fill_dominant(n);
      end
      load_system(0);
      drain();
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
